[rtl/srcvs_pkg.sv]
`default_nettype none

package srcvs_pkg;

  localparam int NUM_SETS_DEF = 2048;
  localparam int NUM_WAYS_DEF = 16;

  localparam int SET_IN_W   = 11;
  localparam int WAY_IN_W   = 4;
  localparam int ADDR_W     = 48;
  localparam int GROUP_W    = 16;
  localparam int GROUP_LSB  = 12;
  localparam int CONF_W     = 3;
  localparam int TS_W       = 64;
  localparam int IV_W       = 32;
  localparam int STREAK_W   = 16;
  localparam int THR_W      = 8;
  localparam int PERIOD_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [THR_W-1:0]    STREAK_THR_RST  = 8'd8;
  localparam logic [PERIOD_W-1:0] MODE_PERIOD_RST = 16'd512;
  localparam logic [CONF_W-1:0]   CONF_MAX        = 3'd7;
  localparam logic [STREAK_W-1:0] STREAK_MAX      = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STREAK_THR  = 2'd0,
    REG_MODE_PERIOD = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [GROUP_W-1:0] group;
    logic [CONF_W-1:0]  conf;
    logic [TS_W-1:0]    ts;
  } blk_ent_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic spatial;
  } rank_ctl_t;

endpackage

`default_nettype wire

[rtl/srcvs_set_reduce.sv]
`default_nettype none

module srcvs_set_reduce
  import srcvs_pkg::*;
#(
  parameter int NUM_SETS = NUM_SETS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SET_IN_W-1:0] value,
  output logic                done,
  output logic [SET_IN_W-1:0] result
);

  localparam int SHIFT   = 2 * SET_IN_W;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = SET_IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / NUM_SETS);

  logic [PROD_W-1:0]   prod;
  logic [SET_IN_W-1:0] x;
  logic [SET_IN_W-1:0] quot;
  logic [SET_IN_W-1:0] rem_est;
  logic                p1;
  logic                p2;

  // quotient estimate is exact or one low; one compare and subtract corrects it
  assign prod = PROD_W'(value) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1   <= 1'b0;
      p2   <= 1'b0;
      done <= 1'b0;
    end else begin
      p1   <= start;
      p2   <= p1;
      done <= p2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= value;
      quot <= prod[SHIFT +: SET_IN_W];
    end
    if (p1) begin
      rem_est <= x - SET_IN_W'(quot * NUM_SETS);
    end
    if (p2) begin
      result <= (int'(rem_est) >= NUM_SETS) ? rem_est - SET_IN_W'(NUM_SETS) : rem_est;
    end
  end

endmodule

`default_nettype wire

[rtl/srcvs_rank.sv]
`default_nettype none

module srcvs_rank
  import srcvs_pkg::*;
#(
  parameter int NUM_WAYS = NUM_WAYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rank_ctl_t                     ctl,
  input  blk_ent_t                      cand,
  input  logic [$clog2(NUM_WAYS)-1:0]   cand_way,
  input  logic [GROUP_W-1:0]            req_group,
  input  logic [IV_W-1:0]               now_lo,
  output logic                          found,
  output logic [$clog2(NUM_WAYS)-1:0]   best_way
);

  logic [IV_W-1:0]   best_iv;
  logic [CONF_W-1:0] best_conf;
  logic [TS_W-1:0]   best_ts;
  logic [IV_W-1:0]   iv;
  logic              skip;
  logic              better;

  assign skip = ctl.spatial && (cand.group == req_group);
  assign iv   = ctl.spatial ? '0 : (now_lo - cand.ts[IV_W-1:0]);

  always_comb begin
    better = !found || (iv > best_iv) ||
             ((iv == best_iv) && ((cand.conf < best_conf) ||
              ((cand.conf == best_conf) && (cand.ts < best_ts))));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.step && !skip && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && !skip && better) begin
      best_iv   <= iv;
      best_conf <= cand.conf;
      best_ts   <= cand.ts;
      best_way  <= cand_way;
    end
  end

endmodule

`default_nettype wire

[rtl/spatial_reuse_cache_victim_select_core.sv]
// Channel   Handshake                 Payload
// config    cfg_write                 cfg_index, cfg_data
// input     in_valid / in_stall       mode, set_index, way_index, phys_address, was_hit
// output    out_valid / out_stall     evict_way
//
// Update: accept, address, block read, block write.
// Victim request: set read, set update, then one block-memory read port scanned one way a
// cycle into the shared ranking unit, drain, check; spatial mode that finds no way rescans.
// NUM_SETS below 2048 and not a power of two, or a single set, adds a set reduction step.
// Reset starts a clearing sweep of all NUM_SETS * NUM_WAYS blocks (32768 by default) with
// in_stall high; config writes are taken during it.
// A held result in the output register stalls only the end of the next victim request.
`default_nettype none

module spatial_reuse_cache_victim_select_core
  import srcvs_pkg::*;
#(
  parameter int NUM_SETS = NUM_SETS_DEF,
  parameter int NUM_WAYS = NUM_WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [SET_IN_W-1:0]   set_index,
  input  logic [WAY_IN_W-1:0]   way_index,
  input  logic [ADDR_W-1:0]     phys_address,
  input  logic                  was_hit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WAY_IN_W-1:0]   evict_way
);

  localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W    = $clog2(NUM_WAYS);
  localparam int NUM_BLKS = NUM_SETS * NUM_WAYS;
  localparam int BLK_W    = $clog2(NUM_BLKS);
  localparam bit NEED_MOD = (NUM_SETS < (1 << SET_IN_W)) &&
                            ((NUM_SETS == 1) || ((NUM_SETS & (NUM_SETS - 1)) != 0));

  typedef struct packed {
    logic [GROUP_W-1:0]  prev_group;
    logic [STREAK_W-1:0] streak;
    logic                spatial;
    logic [TS_W-1:0]     stamp;
  } set_ent_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_ADDR,
    ST_UREAD,
    ST_UWRITE,
    ST_SREAD,
    ST_SUPD,
    ST_SCAN,
    ST_DRAIN,
    ST_CHECK
  } state_t;

  state_t state, state_next;

  logic [THR_W-1:0]    thr;
  logic [PERIOD_W-1:0] period;
  logic [TS_W-1:0]     acc;

  logic                req_mode;
  logic [SET_IN_W-1:0] req_set;
  logic [WAY_IN_W-1:0] req_way;
  logic [GROUP_W-1:0]  req_group;
  logic                req_hit;

  logic [SET_W-1:0] set_q;
  logic [BLK_W-1:0] base;
  logic [BLK_W-1:0] clr_addr;
  logic [WAY_W-1:0] scan_w;
  logic [WAY_W-1:0] cand_way;
  logic             cand_valid;
  logic             pass_spatial;

  blk_ent_t blk_mem [NUM_BLKS];
  set_ent_t set_mem [NUM_SETS];
  blk_ent_t blk_rd;
  set_ent_t set_rd;

  logic             blk_we;
  logic [BLK_W-1:0] blk_waddr;
  logic [BLK_W-1:0] blk_raddr;
  blk_ent_t         blk_wdata;
  logic             set_we;
  logic [SET_W-1:0] set_waddr;
  set_ent_t         set_wdata;

  logic                    accept;
  logic                    out_free;
  logic                    restart;
  logic                    red_done;
  logic [SET_IN_W-1:0]     red_result;
  logic [SET_IN_W-1:0]     set_src;
  logic [SET_W+SET_IN_W-1:0] set_ext;
  logic [SET_W-1:0]        set_sel;
  logic [WAY_W+WAY_IN_W-1:0] way_ext;
  logic [WAY_W-1:0]        upd_way;
  logic                    way_ok;
  logic [WAY_W+WAY_IN_W-1:0] vw_ext;

  logic                rank_found;
  logic [WAY_W-1:0]    rank_way;
  rank_ctl_t           rank_ctl;

  logic [STREAK_W-1:0] streak_n;
  logic [TS_W-1:0]     since;
  logic                eval;
  logic                spatial_n;
  logic [CONF_W-1:0]   conf_n;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign restart  = (state == ST_CHECK) && pass_spatial && !rank_found;

  assign set_src = NEED_MOD ? red_result : req_set;
  assign set_ext = {{SET_W{1'b0}}, set_src};
  assign set_sel = set_ext[SET_W-1:0];
  assign way_ext = {{WAY_W{1'b0}}, req_way};
  assign upd_way = way_ext[WAY_W-1:0];
  assign way_ok  = int'(req_way) < NUM_WAYS;
  assign vw_ext  = {{WAY_IN_W{1'b0}}, rank_way};

  srcvs_set_reduce #(
    .NUM_SETS (NUM_SETS)
  ) u_reduce (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .value  (set_index),
    .done   (red_done),
    .result (red_result)
  );

  assign rank_ctl.clear   = (state == ST_SUPD) || restart;
  assign rank_ctl.step    = cand_valid;
  assign rank_ctl.spatial = pass_spatial;

  srcvs_rank #(
    .NUM_WAYS (NUM_WAYS)
  ) u_rank (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rank_ctl),
    .cand      (blk_rd),
    .cand_way  (cand_way),
    .req_group (req_group),
    .now_lo    (acc[IV_W-1:0]),
    .found     (rank_found),
    .best_way  (rank_way)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= STREAK_THR_RST;
      period <= MODE_PERIOD_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_STREAK_THR:  thr    <= cfg_data[THR_W-1:0];
        REG_MODE_PERIOD: period <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (set_rd.prev_group == req_group) begin
      streak_n = (set_rd.streak == STREAK_MAX) ? set_rd.streak : set_rd.streak + 1'b1;
    end else begin
      streak_n = STREAK_W'(1);
    end
    since     = acc - set_rd.stamp;
    eval      = since > TS_W'(period);
    spatial_n = eval ? (streak_n > STREAK_W'(thr)) : set_rd.spatial;
  end

  always_comb begin
    if (req_hit) begin
      conf_n = (blk_rd.conf == CONF_MAX) ? blk_rd.conf : blk_rd.conf + 1'b1;
    end else begin
      conf_n = (blk_rd.conf == '0) ? blk_rd.conf : blk_rd.conf - 1'b1;
    end
  end

  always_comb begin
    blk_raddr       = base + BLK_W'((state == ST_UREAD) ? upd_way : scan_w);
    blk_we          = (state == ST_CLEAR) || (state == ST_UWRITE);
    blk_waddr       = (state == ST_CLEAR) ? clr_addr : base + BLK_W'(upd_way);
    blk_wdata.group = req_group;
    blk_wdata.conf  = conf_n;
    blk_wdata.ts    = acc;
    if (state == ST_CLEAR) begin
      blk_wdata = '0;
    end
    set_we               = ((state == ST_CLEAR) && (clr_addr < BLK_W'(NUM_SETS))) ||
                           (state == ST_SUPD);
    set_waddr            = (state == ST_CLEAR) ? clr_addr[SET_W-1:0] : set_q;
    set_wdata.prev_group = req_group;
    set_wdata.streak     = streak_n;
    set_wdata.spatial    = spatial_n;
    set_wdata.stamp      = eval ? acc : set_rd.stamp;
    if (state == ST_CLEAR) begin
      set_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    blk_rd <= blk_mem[blk_raddr];
  end

  always_ff @(posedge clk) begin
    if (set_we) begin
      set_mem[set_waddr] <= set_wdata;
    end
    set_rd <= set_mem[set_q];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_addr == BLK_W'(NUM_BLKS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = NEED_MOD ? ST_MOD : ST_ADDR;
      ST_MOD:    if (red_done) state_next = ST_ADDR;
      ST_ADDR: begin
        if (!req_mode) begin
          state_next = ST_SREAD;
        end else begin
          state_next = way_ok ? ST_UREAD : ST_IDLE;
        end
      end
      ST_UREAD:  state_next = ST_UWRITE;
      ST_UWRITE: state_next = ST_IDLE;
      ST_SREAD:  state_next = ST_SUPD;
      ST_SUPD:   state_next = ST_SCAN;
      ST_SCAN:   if (scan_w == WAY_W'(NUM_WAYS - 1)) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (restart) begin
          state_next = ST_SCAN;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_CHECK) && !restart && out_free) begin
        out_valid <= 1'b1;
        evict_way <= vw_ext[WAY_IN_W-1:0];
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      clr_addr     <= '0;
      scan_w       <= '0;
      cand_valid   <= 1'b0;
      pass_spatial <= 1'b0;
    end else begin
      cand_valid <= (state == ST_SCAN);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept) begin
        acc <= acc + 1'b1;
      end
      if (state == ST_SUPD) begin
        scan_w       <= '0;
        pass_spatial <= spatial_n;
      end else if (restart) begin
        scan_w       <= '0;
        pass_spatial <= 1'b0;
      end else if (state == ST_SCAN) begin
        scan_w <= scan_w + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode  <= mode;
      req_set   <= set_index;
      req_way   <= way_index;
      req_group <= phys_address[GROUP_LSB +: GROUP_W];
      req_hit   <= was_hit;
    end
    if (state == ST_ADDR) begin
      set_q <= set_sel;
      base  <= BLK_W'(set_sel) * BLK_W'(NUM_WAYS);
    end
    if (state == ST_SCAN) begin
      cand_way <= scan_w;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("block took a second item while busy");

  a_interval_pass_finds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) && !pass_spatial |-> rank_found)
    else $error("interval pass ended with no victim");

  a_clear_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !out_valid)
    else $error("result during clearing sweep");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (int'(scan_w) < NUM_WAYS))
    else $error("scan index beyond way count");
`endif

endmodule

`default_nettype wire

[bench/srcvs_tb_pkg.sv]
package srcvs_tb_pkg;

  typedef enum logic {
    REQ_VICTIM = 1'b0,
    REQ_UPDATE = 1'b1
  } req_kind_t;

endpackage

[bench/victim_select_checker.sv]
module victim_select_checker
  import srcvs_pkg::*;
  import srcvs_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  mode,
  input  logic [SET_IN_W-1:0]   set_index,
  input  logic [WAY_IN_W-1:0]   way_index,
  input  logic [ADDR_W-1:0]     phys_address,
  input  logic                  was_hit,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [WAY_IN_W-1:0]   evict_way,
  output int                    fail_count,
  output int                    outstanding
);

  localparam int NUM_BLOCKS = NUM_SETS_DEF * NUM_WAYS_DEF;

  logic [THR_W-1:0]    streak_thr;
  logic [PERIOD_W-1:0] mode_period;
  logic [TS_W-1:0]     access_cnt;

  logic [GROUP_W-1:0]  blk_group [NUM_BLOCKS];
  logic [CONF_W-1:0]   blk_conf  [NUM_BLOCKS];
  logic [TS_W-1:0]     blk_ts    [NUM_BLOCKS];

  logic [GROUP_W-1:0]  set_group   [NUM_SETS_DEF];
  logic [STREAK_W-1:0] set_streak  [NUM_SETS_DEF];
  logic                set_spatial [NUM_SETS_DEF];
  logic [TS_W-1:0]     set_stamp   [NUM_SETS_DEF];

  logic [WAY_IN_W-1:0] evict_way_q [$];
  int                  mismatches = 0;

  function automatic logic [WAY_IN_W-1:0] choose_victim_way(int unsigned s,
                                                            logic [GROUP_W-1:0] grp);
    int unsigned    base;
    int unsigned    pick;
    logic [CONF_W-1:0] c;
    logic [CONF_W-1:0] best_conf;
    logic [TS_W-1:0]   t;
    logic [TS_W-1:0]   best_ts;
    logic [IV_W-1:0]   iv;
    logic [IV_W-1:0]   best_iv;
    bit             found;
    base = s * NUM_WAYS_DEF;
    pick = 0;
    best_conf = '0;
    best_ts = '0;
    best_iv = '0;
    found = 1'b0;
    if (set_spatial[s]) begin
      for (int w = 0; w < NUM_WAYS_DEF; w++) begin
        c = blk_conf[base + w];
        t = blk_ts[base + w];
        if (blk_group[base + w] != grp) begin
          if (!found || c < best_conf || (c == best_conf && t < best_ts)) begin
            pick = w;
            best_conf = c;
            best_ts = t;
            found = 1'b1;
          end
        end
      end
      if (found) return pick[WAY_IN_W-1:0];
    end
    for (int w = 0; w < NUM_WAYS_DEF; w++) begin
      c = blk_conf[base + w];
      t = blk_ts[base + w];
      iv = IV_W'(access_cnt - t);
      if (!found || iv > best_iv || (iv == best_iv && c < best_conf) ||
          (iv == best_iv && c == best_conf && t < best_ts)) begin
        pick = w;
        best_iv = iv;
        best_conf = c;
        best_ts = t;
        found = 1'b1;
      end
    end
    return pick[WAY_IN_W-1:0];
  endfunction

  always @(posedge clk) begin : monitor
    int unsigned        s;
    int unsigned        idx;
    logic [GROUP_W-1:0] grp;
    logic [WAY_IN_W-1:0] exp_way;
    if (rst) begin
      streak_thr = STREAK_THR_RST;
      mode_period = MODE_PERIOD_RST;
      access_cnt = '0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        blk_group[i] = '0;
        blk_conf[i] = '0;
        blk_ts[i] = '0;
      end
      for (int i = 0; i < NUM_SETS_DEF; i++) begin
        set_group[i] = '0;
        set_streak[i] = '0;
        set_spatial[i] = 1'b0;
        set_stamp[i] = '0;
      end
      evict_way_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_STREAK_THR:  streak_thr = cfg_data[THR_W-1:0];
          REG_MODE_PERIOD: mode_period = cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (evict_way_q.size() == 0) begin
          $error("evict_way: expected none, actual %0d", evict_way);
          mismatches++;
        end else begin
          exp_way = evict_way_q.pop_front();
          if (evict_way !== exp_way) begin
            $error("evict_way: expected %0d, actual %0d", exp_way, evict_way);
            mismatches++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        s = set_index % NUM_SETS_DEF;
        grp = phys_address[GROUP_LSB +: GROUP_W];
        access_cnt = access_cnt + 1;
        if (mode == REQ_VICTIM) begin
          if (set_group[s] == grp) begin
            if (set_streak[s] != STREAK_MAX) set_streak[s] = set_streak[s] + 1'b1;
          end else begin
            set_streak[s] = STREAK_W'(1);
            set_group[s] = grp;
          end
          if (access_cnt - set_stamp[s] > TS_W'(mode_period)) begin
            set_spatial[s] = (set_streak[s] > STREAK_W'(streak_thr));
            set_stamp[s] = access_cnt;
          end
          evict_way_q.push_back(choose_victim_way(s, grp));
        end else if (way_index < NUM_WAYS_DEF) begin
          idx = s * NUM_WAYS_DEF + way_index;
          blk_group[idx] = grp;
          if (was_hit) begin
            if (blk_conf[idx] != CONF_MAX) blk_conf[idx] = blk_conf[idx] + 1'b1;
          end else begin
            if (blk_conf[idx] != '0) blk_conf[idx] = blk_conf[idx] - 1'b1;
          end
          blk_ts[idx] = access_cnt;
        end
      end
    end
    fail_count <= mismatches;
    outstanding <= evict_way_q.size();
  end

endmodule

[bench/tb_spatial_reuse_cache_victim_select_core.sv]
module tb_spatial_reuse_cache_victim_select_core;
  import srcvs_pkg::*;
  import srcvs_tb_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 64;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  mode = 1'b0;
  logic [SET_IN_W-1:0]   set_index = '0;
  logic [WAY_IN_W-1:0]   way_index = '0;
  logic [ADDR_W-1:0]     phys_address = '0;
  logic                  was_hit = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WAY_IN_W-1:0]   evict_way;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  spatial_reuse_cache_victim_select_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .set_index    (set_index),
    .way_index    (way_index),
    .phys_address (phys_address),
    .was_hit      (was_hit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .evict_way    (evict_way)
  );

  victim_select_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .set_index    (set_index),
    .way_index    (way_index),
    .phys_address (phys_address),
    .was_hit      (was_hit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .evict_way    (evict_way),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin : out_stall_gen
    int          stall_run = 0;
    bit [1:0]    stall_style = 2'd0;
    if (stall_run == 0) begin
      stall_style = 2'($urandom_range(3));
      stall_run = $urandom_range(200, 20);
    end
    stall_run--;
    case (stall_style)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(3) == 0);
      2'd2: out_stall <= ($urandom_range(3) != 0);
      default: out_stall <= ($urandom_range(15) == 0) ? ~out_stall : out_stall;
    endcase
  end

  // hold the payload until the transfer, then return at the transfer edge
  task automatic send_item(req_kind_t kind, logic [SET_IN_W-1:0] s, logic [WAY_IN_W-1:0] w,
                           logic [ADDR_W-1:0] a, logic h);
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      if (gaps_on) begin
        in_valid <= 1'b0;
        if ($urandom_range(7) == 0) repeat ($urandom_range(40, 5)) @(posedge clk);
        else repeat ($urandom_range(3, 1)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    mode <= kind;
    set_index <= s;
    way_index <= w;
    phys_address <= a;
    was_hit <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [THR_W-1:0] thr, logic [PERIOD_W-1:0] period);
    cfg_write <= 1'b1;
    cfg_index <= REG_STREAK_THR;
    cfg_data <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_index <= REG_MODE_PERIOD;
    cfg_data <= period;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // runs of victim requests on one set and page group, mixed with updates and noise
  task automatic run_random_phase(int unsigned n_items);
    logic [SET_IN_W-1:0] set_pool [4];
    logic [GROUP_W-1:0]  group_pool [3];
    logic [SET_IN_W-1:0] s;
    logic [GROUP_W-1:0]  g;
    logic [ADDR_W-1:0]   a;
    int unsigned         run_len;
    int unsigned         sent;
    set_pool[0] = '0;
    set_pool[1] = '1;
    set_pool[2] = SET_IN_W'($urandom);
    set_pool[3] = SET_IN_W'($urandom);
    group_pool[0] = '0;
    group_pool[1] = '1;
    group_pool[2] = GROUP_W'($urandom);
    sent = 0;
    while (sent < n_items) begin
      s = set_pool[$urandom_range(3)];
      g = group_pool[$urandom_range(2)];
      run_len = $urandom_range(12, 1);
      for (int i = 0; i < run_len; i++) begin
        a = ADDR_W'({$urandom, $urandom});
        if ($urandom_range(4) == 0) begin
          send_item($urandom_range(1) ? REQ_UPDATE : REQ_VICTIM, SET_IN_W'($urandom),
                    WAY_IN_W'($urandom), a, 1'($urandom_range(1)));
        end else if ($urandom_range(9) < 6) begin
          a[GROUP_LSB +: GROUP_W] = g;
          send_item(REQ_VICTIM, s, WAY_IN_W'($urandom), a, 1'($urandom_range(1)));
        end else begin
          a[GROUP_LSB +: GROUP_W] = group_pool[$urandom_range(2)];
          send_item(REQ_UPDATE, s, WAY_IN_W'($urandom), a, $urandom_range(9) < 6);
        end
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_item(REQ_VICTIM, 11'd0, 4'd0, 48'h0, 1'b0);
    send_item(REQ_VICTIM, 11'h7FF, 4'hF, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_item(REQ_UPDATE, 11'h7FF, 4'hF, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_item(REQ_UPDATE, 11'h7FF, 4'd0, 48'h0, 1'b0);
    repeat (8) send_item(REQ_UPDATE, 11'd5, 4'd3, 48'h0000_0005_6000, 1'b1);
    send_item(REQ_UPDATE, 11'd5, 4'd3, 48'h0000_0005_6000, 1'b0);
    send_item(REQ_VICTIM, 11'd5, 4'd0, 48'h0000_0005_6000, 1'b0);
    send_item(REQ_VICTIM, 11'h7FF, 4'd0, 48'hFFFF_FFFF_FFFF, 1'b0);
    run_random_phase(150);

    wait_drained();
    write_config(8'd0, 16'd0);
    send_item(REQ_UPDATE, 11'd9, 4'd4, 48'h0000_0123_4000, 1'b1);
    send_item(REQ_UPDATE, 11'd9, 4'd7, 48'h0000_0123_4000, 1'b0);
    send_item(REQ_VICTIM, 11'd9, 4'd0, 48'h0000_0123_4000, 1'b0);
    send_item(REQ_VICTIM, 11'd12, 4'd0, 48'h0000_0000_0000, 1'b0);
    send_item(REQ_UPDATE, 11'd9, 4'd0, 48'h0000_0ABC_D000, 1'b1);
    send_item(REQ_VICTIM, 11'd9, 4'd0, 48'h0000_0123_4000, 1'b0);
    run_random_phase(250);

    wait_drained();
    write_config(8'd255, 16'hFFFF);
    run_random_phase(150);

    wait_drained();
    write_config(8'd3, 16'd5);
    gaps_on = 1'b0;
    run_random_phase(250);

    wait_drained();
    write_config(THR_W'($urandom_range(10)), PERIOD_W'($urandom_range(40)));
    gaps_on = 1'b1;
    run_random_phase(200);

    wait_drained();
    write_config(THR_W'($urandom), PERIOD_W'($urandom));
    run_random_phase(150);

    wait_drained();
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[spatial_reuse_cache_victim_select_core.f]
rtl/srcvs_pkg.sv
rtl/srcvs_set_reduce.sv
rtl/srcvs_rank.sv
rtl/spatial_reuse_cache_victim_select_core.sv
bench/srcvs_tb_pkg.sv
bench/victim_select_checker.sv
bench/tb_spatial_reuse_cache_victim_select_core.sv
